// ===== rtl/core/contour_band_depth_ranker_core_assert.svh =====
// Assertion macros for the contour band depth ranker core.
// Needs clk and arst_n in the scope of the including module.
`ifndef CONTOUR_BAND_DEPTH_RANKER_CORE_ASSERT_SVH
`define CONTOUR_BAND_DEPTH_RANKER_CORE_ASSERT_SVH

// hold in the same cycle
`define CBDR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbdr assertion failed");

// hold in the next cycle
`define CBDR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbdr assertion failed");

`endif

// ===== rtl/core/cbdr_pkg.sv =====
// Shared types and constants of the contour band depth ranker core.
// No dependencies.
package cbdr_pkg;

	localparam int MAX_MEMBERS = 32;
	localparam int MAX_GRIDS   = 4096;
	localparam int MEM_W       = 5;
	localparam int GRID_W      = 12;
	localparam int CNT_W       = 13;
	localparam int PAIR_W      = 9;
	localparam int HIST_DEPTH  = MAX_GRIDS + 1;
	localparam int HIST_AW     = 13;
	localparam int HIST_W      = 14;
	localparam int PM_AW       = MEM_W + PAIR_W;
	localparam int DEPTH_W     = 9;
	localparam int TYPE_W      = 2;
	localparam int CUM6_W      = 17;

	localparam logic [TYPE_W-1:0] TYPE_OUTLIER  = 2'd0;
	localparam logic [TYPE_W-1:0] TYPE_ORDINARY = 2'd1;
	localparam logic [TYPE_W-1:0] TYPE_DEEP     = 2'd2;

	typedef enum logic [1:0] {
		REG_ISO_LEVEL,
		REG_MEMBER_COUNT,
		REG_GRID_COUNT,
		REG_OUTLIER_THRESHOLD
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] sample_value;
		logic               last_sample;
	} cbdr_in_t;

	typedef struct packed {
		logic [4:0] member_index;
		logic [8:0] band_depth;
		logic [1:0] member_type;
		logic       last_member;
	} cbdr_out_t;

	typedef struct packed {
		logic             clear;
		logic             en;
		logic [MEM_W-1:0] sel_j;
		logic [MEM_W-1:0] sel_k;
	} lane_ctl_t;

endpackage

// ===== rtl/core/contour_band_depth_ranker_core.sv =====
// Contour band depth ranker: loads one sample per cycle into a column mask memory;
// the request flagged last_sample starts the ranking, which clears the histogram memory,
// then for each of the P = (n-1)*n/2 member pairs scans the mask memory column by column
// over the g grid points and does a read-modify-write of the histogram memory, then picks
// epsilon, accumulates the depths, classifies the members and selects the deep ones;
// then n results stream out, one per cycle unless stalled. Input stalls meanwhile.
module contour_band_depth_ranker_core
	import cbdr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  cbdr_in_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output cbdr_out_t   out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_LOAD, ST_CLEAR, ST_SCAN, ST_DRAIN, ST_HRD, ST_HWR, ST_NEXT,
		ST_EPS_RD, ST_EPS_ACC, ST_DEP, ST_DEP_DRAIN, ST_CLASS, ST_SEL, ST_OUT
	} state_t;

	state_t state_q;

	logic signed [15:0] iso_q;
	logic [5:0]         mc_q;
	logic [12:0]        gc_q;
	logic [8:0]         thr_q;

	logic [5:0]         n_eff;
	logic [12:0]        g_eff;
	logic [PAIR_W-1:0]  mset_q;
	logic [HIST_W-1:0]  total_q;

	logic [5:0]         ld_mem_q;
	logic [12:0]        ld_grid_q;
	logic [HIST_AW-1:0] clr_q;
	logic [GRID_W-1:0]  w_q;
	logic               scan_s1;
	logic [MEM_W-1:0]   j_q;
	logic [MEM_W-1:0]   k_q;
	logic [PAIR_W-1:0]  p_q;
	logic [MEM_W-1:0]   l_q;
	logic [HIST_AW-1:0] idx_q;
	logic [HIST_W-1:0]  cum_q;
	logic [CNT_W-1:0]   eps_q;
	logic [MEM_W-1:0]   mi_q;
	logic               dep_v_s1;
	logic               dep_last_s1;
	logic [MEM_W-1:0]   dep_i_s1;
	logic [DEPTH_W-1:0] dcnt_q;
	logic [5:0]         outl_q;
	logic [4:0]         rounds_q;
	logic [4:0]         r_q;
	logic [DEPTH_W-1:0] best_q;
	logic [MEM_W-1:0]   pick_q;
	logic               found_q;

	logic [DEPTH_W-1:0] depth_q [MAX_MEMBERS];
	logic [TYPE_W-1:0]  type_q [MAX_MEMBERS];

	logic               in_acc;
	logic               out_acc;
	logic               above;

	logic                   mask_we;
	logic [MAX_MEMBERS-1:0] mask_wmask;
	logic [MAX_MEMBERS-1:0] mask_rdata;
	logic                   hist_we;
	logic [HIST_AW-1:0]     hist_waddr;
	logic [HIST_W-1:0]      hist_wdata;
	logic [HIST_AW-1:0]     hist_raddr;
	logic [HIST_W-1:0]      hist_rdata;
	logic                   pm_we;
	logic [CNT_W-1:0]       pm_rdata;
	lane_ctl_t              lane_ctl;
	logic [CNT_W-1:0]       mismatch;

	logic               lane_used;
	logic               last_lane;
	logic               pair_wrap;
	logic               last_pair;
	logic [HIST_W-1:0]  cum_n;
	logic [CUM6_W-1:0]  cum6_n;
	logic [CNT_W-1:0]   eps_n;
	logic               eps_go;
	logic               dep_hit;
	logic               is_outl;
	logic [5:0]         outl_n;
	logic               cand;
	logic               found_f;
	logic [MEM_W-1:0]   pick_f;

	always_comb begin
		if (mc_q < 6'd3) begin
			n_eff = 6'd3;
		end else if (mc_q > 6'(MAX_MEMBERS)) begin
			n_eff = 6'(MAX_MEMBERS);
		end else begin
			n_eff = mc_q;
		end
		if (gc_q == '0) begin
			g_eff = 13'd1;
		end else if (gc_q > 13'(MAX_GRIDS)) begin
			g_eff = 13'(MAX_GRIDS);
		end else begin
			g_eff = gc_q;
		end
	end

	assign in_stall  = (state_q != ST_LOAD);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign out_acc   = out_valid && !out_stall;
	assign above     = in_data.sample_value > iso_q;

	assign out_data.member_index = mi_q;
	assign out_data.band_depth   = depth_q[mi_q];
	assign out_data.member_type  = type_q[mi_q];
	assign out_data.last_member  = ({1'b0, mi_q} == n_eff - 6'd1);

	// mask memory
	assign mask_we    = in_acc && (ld_mem_q < n_eff) && (ld_grid_q < g_eff);
	assign mask_wmask = MAX_MEMBERS'(1) << ld_mem_q[MEM_W-1:0];

	cbdr_ram #(.WIDTH(MAX_MEMBERS), .DEPTH(MAX_GRIDS)) u_mask (
		.clk   (clk),
		.we    (mask_we),
		.wmask (mask_wmask),
		.waddr (ld_grid_q[GRID_W-1:0]),
		.wdata ({MAX_MEMBERS{above}}),
		.raddr (w_q),
		.rdata (mask_rdata)
	);

	assign lane_ctl.clear = (state_q == ST_CLEAR) || (state_q == ST_NEXT);
	assign lane_ctl.en    = scan_s1;
	assign lane_ctl.sel_j = j_q;
	assign lane_ctl.sel_k = k_q;

	cbdr_lanes u_lanes (
		.clk      (clk),
		.ctl      (lane_ctl),
		.column   (mask_rdata),
		.rd_idx   (l_q),
		.mismatch (mismatch)
	);

	// histogram memory
	assign lane_used  = ({1'b0, l_q} < n_eff) && (l_q != j_q) && (l_q != k_q);
	assign hist_we    = (state_q == ST_CLEAR) || (state_q == ST_HWR);
	assign hist_waddr = (state_q == ST_CLEAR) ? clr_q : mismatch;
	assign hist_wdata = (state_q == ST_CLEAR) ? '0 : hist_rdata + HIST_W'(1);
	assign hist_raddr = (state_q == ST_HRD) ? mismatch : idx_q;

	cbdr_ram #(.WIDTH(HIST_W), .DEPTH(HIST_DEPTH)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.wmask ({HIST_W{1'b1}}),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	// pair mismatch memory
	assign pm_we = (state_q == ST_HRD) && lane_used;

	cbdr_ram #(.WIDTH(CNT_W), .DEPTH(MAX_MEMBERS * (1 << PAIR_W))) u_pm (
		.clk   (clk),
		.we    (pm_we),
		.wmask ({CNT_W{1'b1}}),
		.waddr ({l_q, p_q}),
		.wdata (mismatch),
		.raddr ({mi_q, p_q}),
		.rdata (pm_rdata)
	);

	assign last_lane = ({1'b0, l_q} == n_eff - 6'd1);
	assign pair_wrap = (k_q + MEM_W'(1) == j_q);
	assign last_pair = pair_wrap && ({1'b0, j_q} == n_eff - 6'd1);

	assign cum_n  = cum_q + hist_rdata;
	assign cum6_n = {1'b0, cum_n, 2'b00} + {2'b00, cum_n, 1'b0};
	assign eps_n  = idx_q + HIST_AW'(1);
	assign eps_go = (cum6_n <= CUM6_W'(total_q)) && (eps_n <= CNT_W'(MAX_GRIDS));

	assign dep_hit = pm_rdata < eps_q;
	assign is_outl = depth_q[mi_q] < thr_q;
	assign outl_n  = outl_q + 6'(is_outl);
	assign cand    = (type_q[mi_q] == TYPE_ORDINARY) && (depth_q[mi_q] > best_q);
	assign found_f = found_q || cand;
	assign pick_f  = cand ? mi_q : pick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			iso_q       <= '0;
			mc_q        <= 6'(MAX_MEMBERS);
			gc_q        <= 13'(MAX_GRIDS);
			thr_q       <= '0;
			mset_q      <= '0;
			total_q     <= '0;
			ld_mem_q    <= '0;
			ld_grid_q   <= '0;
			clr_q       <= '0;
			w_q         <= '0;
			scan_s1     <= 1'b0;
			j_q         <= '0;
			k_q         <= '0;
			p_q         <= '0;
			l_q         <= '0;
			idx_q       <= '0;
			cum_q       <= '0;
			eps_q       <= CNT_W'(1);
			mi_q        <= '0;
			dep_v_s1    <= 1'b0;
			dep_last_s1 <= 1'b0;
			dep_i_s1    <= '0;
			dcnt_q      <= '0;
			outl_q      <= '0;
			rounds_q    <= '0;
			r_q         <= '0;
			best_q      <= '0;
			pick_q      <= '0;
			found_q     <= 1'b0;
			for (int m = 0; m < MAX_MEMBERS; m++) begin
				depth_q[m] <= '0;
				type_q[m]  <= TYPE_ORDINARY;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_ISO_LEVEL:         iso_q <= cfg_data;
					REG_MEMBER_COUNT:      mc_q  <= cfg_data[5:0];
					REG_GRID_COUNT:        gc_q  <= cfg_data[12:0];
					REG_OUTLIER_THRESHOLD: thr_q <= cfg_data[8:0];
					default:               iso_q <= iso_q;
				endcase
			end

			mset_q  <= PAIR_W'(({4'b0, n_eff - 6'd1} * {4'b0, n_eff - 6'd2}) >> 1);
			total_q <= HIST_W'({8'b0, n_eff} * {5'b0, mset_q});
			scan_s1 <= (state_q == ST_SCAN);

			// depth accumulation, registered to line up with the pair memory read data
			dep_v_s1    <= (state_q == ST_DEP) && (j_q != mi_q) && (k_q != mi_q);
			dep_last_s1 <= (state_q == ST_DEP) && last_pair;
			dep_i_s1    <= mi_q;
			if (dep_v_s1 || dep_last_s1) begin
				if (dep_last_s1) begin
					depth_q[dep_i_s1] <= dcnt_q + DEPTH_W'(dep_v_s1 && dep_hit);
					dcnt_q            <= '0;
				end else begin
					dcnt_q <= dcnt_q + DEPTH_W'(dep_hit);
				end
			end

			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (in_data.last_sample) begin
							ld_mem_q  <= '0;
							ld_grid_q <= '0;
							clr_q     <= '0;
							state_q   <= ST_CLEAR;
						end else if (ld_mem_q < n_eff) begin
							if (ld_grid_q + 13'd1 >= g_eff) begin
								ld_grid_q <= '0;
								ld_mem_q  <= ld_mem_q + 6'd1;
							end else begin
								ld_grid_q <= ld_grid_q + 13'd1;
							end
						end
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + HIST_AW'(1);
					if (clr_q == HIST_AW'(HIST_DEPTH - 1)) begin
						j_q     <= MEM_W'(1);
						k_q     <= '0;
						p_q     <= '0;
						w_q     <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					w_q <= w_q + GRID_W'(1);
					if ({1'b0, w_q} == g_eff - 13'd1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					l_q     <= '0;
					state_q <= ST_HRD;
				end
				ST_HRD: begin
					if (lane_used) begin
						state_q <= ST_HWR;
					end else if (last_lane) begin
						state_q <= ST_NEXT;
					end else begin
						l_q <= l_q + MEM_W'(1);
					end
				end
				ST_HWR: begin
					if (last_lane) begin
						state_q <= ST_NEXT;
					end else begin
						l_q     <= l_q + MEM_W'(1);
						state_q <= ST_HRD;
					end
				end
				ST_NEXT: begin
					w_q <= '0;
					p_q <= p_q + PAIR_W'(1);
					if (pair_wrap) begin
						k_q <= '0;
						j_q <= j_q + MEM_W'(1);
					end else begin
						k_q <= k_q + MEM_W'(1);
					end
					if (last_pair) begin
						idx_q   <= '0;
						cum_q   <= '0;
						state_q <= ST_EPS_RD;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_EPS_RD: begin
					state_q <= ST_EPS_ACC;
				end
				ST_EPS_ACC: begin
					if (eps_go) begin
						cum_q   <= cum_n;
						idx_q   <= idx_q + HIST_AW'(1);
						state_q <= ST_EPS_RD;
					end else begin
						eps_q   <= eps_n;
						mi_q    <= '0;
						j_q     <= MEM_W'(1);
						k_q     <= '0;
						p_q     <= '0;
						dcnt_q  <= '0;
						state_q <= ST_DEP;
					end
				end
				ST_DEP: begin
					if (last_pair) begin
						j_q <= MEM_W'(1);
						k_q <= '0;
						p_q <= '0;
						if ({1'b0, mi_q} == n_eff - 6'd1) begin
							state_q <= ST_DEP_DRAIN;
						end else begin
							mi_q <= mi_q + MEM_W'(1);
						end
					end else begin
						p_q <= p_q + PAIR_W'(1);
						if (pair_wrap) begin
							k_q <= '0;
							j_q <= j_q + MEM_W'(1);
						end else begin
							k_q <= k_q + MEM_W'(1);
						end
					end
				end
				ST_DEP_DRAIN: begin
					mi_q    <= '0;
					outl_q  <= '0;
					state_q <= ST_CLASS;
				end
				ST_CLASS: begin
					type_q[mi_q] <= is_outl ? TYPE_OUTLIER : TYPE_ORDINARY;
					outl_q       <= outl_n;
					if ({1'b0, mi_q} == n_eff - 6'd1) begin
						rounds_q <= 5'((n_eff - outl_n) >> 1);
						r_q      <= '0;
						mi_q     <= '0;
						best_q   <= '0;
						found_q  <= 1'b0;
						state_q  <= ((n_eff - outl_n) >> 1 == 6'd0) ? ST_OUT : ST_SEL;
					end else begin
						mi_q <= mi_q + MEM_W'(1);
					end
				end
				ST_SEL: begin
					pick_q <= pick_f;
					if ({1'b0, mi_q} == n_eff - 6'd1) begin
						mi_q    <= '0;
						best_q  <= '0;
						found_q <= 1'b0;
						if (!found_f) begin
							state_q <= ST_OUT;
						end else begin
							type_q[pick_f] <= TYPE_DEEP;
							r_q            <= r_q + 5'd1;
							if (r_q + 5'd1 == rounds_q) begin
								state_q <= ST_OUT;
							end
						end
					end else begin
						if (cand) begin
							best_q <= depth_q[mi_q];
						end
						found_q <= found_f;
						mi_q    <= mi_q + MEM_W'(1);
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						if (out_data.last_member) begin
							mi_q    <= '0;
							state_q <= ST_LOAD;
						end else begin
							mi_q <= mi_q + MEM_W'(1);
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

`include "contour_band_depth_ranker_core_assert.svh"

	`CBDR_ASSERT_NOW(a_no_request_while_output, out_valid, in_stall)
	`CBDR_ASSERT_NOW(a_index_in_range, out_valid, ({1'b0, out_data.member_index} < n_eff))
	`CBDR_ASSERT_NEXT(a_last_ends_output, out_acc && out_data.last_member, !out_valid && !in_stall)

endmodule

// ===== rtl/core/cbdr_ram.sv =====
// Simple dual-port synchronous RAM with per-bit write enables.
// Registered read; no dependencies.
module cbdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [WIDTH-1:0] wmask,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			for (int b = 0; b < WIDTH; b++) begin
				if (wmask[b]) begin
					mem[waddr][b] <= wdata[b];
				end
			end
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/cbdr_lanes.sv =====
// Per-member mismatch counters for one member pair, fed one mask column a cycle while enabled.
// Depends on cbdr_pkg.
module cbdr_lanes
	import cbdr_pkg::*;
(
	input  logic                   clk,
	input  lane_ctl_t              ctl,
	input  logic [MAX_MEMBERS-1:0] column,
	input  logic [MEM_W-1:0]       rd_idx,
	output logic [CNT_W-1:0]       mismatch
);

	logic [CNT_W-1:0] a_q [MAX_MEMBERS];
	logic [CNT_W-1:0] b_q [MAX_MEMBERS];
	logic             both_clear;
	logic             both_set;

	assign both_clear = !column[ctl.sel_j] && !column[ctl.sel_k];
	assign both_set   = column[ctl.sel_j] && column[ctl.sel_k];

	always_ff @(posedge clk) begin
		for (int l = 0; l < MAX_MEMBERS; l++) begin
			if (ctl.clear) begin
				a_q[l] <= '0;
				b_q[l] <= '0;
			end else if (ctl.en) begin
				a_q[l] <= a_q[l] + CNT_W'(both_clear && column[l]);
				b_q[l] <= b_q[l] + CNT_W'(both_set && !column[l]);
			end
		end
	end

	assign mismatch = (a_q[rd_idx] > b_q[rd_idx]) ? a_q[rd_idx] : b_q[rd_idx];

endmodule
